@@ rtl/tesp_pkg.sv @@
`default_nettype none

package tesp_pkg;

    // Parameter collection
    localparam int MAX_PARAMS = 4;
    localparam int OUT_SLOTS  = 4;
    localparam int PARAM_W    = 16;
    localparam int FILL_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int ACTION_W   = 6;
    localparam int TDATA_W    = 88;

    // C0 control bytes and other fixed codes
    localparam logic [BYTE_W-1:0] C_ETX     = 8'h03;
    localparam logic [BYTE_W-1:0] C_ENQ     = 8'h05;
    localparam logic [BYTE_W-1:0] C_BEL     = 8'h07;
    localparam logic [BYTE_W-1:0] C_BS      = 8'h08;
    localparam logic [BYTE_W-1:0] C_HT      = 8'h09;
    localparam logic [BYTE_W-1:0] C_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] C_VT      = 8'h0B;
    localparam logic [BYTE_W-1:0] C_FF      = 8'h0C;
    localparam logic [BYTE_W-1:0] C_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] C_SO      = 8'h0E;
    localparam logic [BYTE_W-1:0] C_SI      = 8'h0F;
    localparam logic [BYTE_W-1:0] C_XON     = 8'h11;
    localparam logic [BYTE_W-1:0] C_XOFF    = 8'h13;
    localparam logic [BYTE_W-1:0] C_CAN     = 8'h18;
    localparam logic [BYTE_W-1:0] C_SUB     = 8'h1A;
    localparam logic [BYTE_W-1:0] C_ESC     = 8'h1B;
    localparam logic [BYTE_W-1:0] C_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] C_DEL     = 8'h7F;
    localparam logic [BYTE_W-1:0] CHAR_ERR  = 8'd176;

    // Charset designator codes
    localparam logic [BYTE_W-1:0] CS_UK         = 8'd0;
    localparam logic [BYTE_W-1:0] CS_ASCII      = 8'd1;
    localparam logic [BYTE_W-1:0] CS_GRAPHICS   = 8'd2;
    localparam logic [BYTE_W-1:0] CS_ALTROM     = 8'd3;
    localparam logic [BYTE_W-1:0] CS_ALTROM_GFX = 8'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ESC,
        ST_CSI,
        ST_PRIV,
        ST_HASH,
        ST_G0,
        ST_G1,
        ST_ESCO,
        ST_CDA
    } parse_state_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PRINT, ACT_ACK, ACT_ANSWERBACK, ACT_BELL, ACT_HT, ACT_BS, ACT_LF, ACT_CR,
        ACT_XON, ACT_XOFF, ACT_SI, ACT_SO, ACT_DECSC, ACT_DECRC, ACT_RIS, ACT_IND,
        ACT_NEL, ACT_HTS, ACT_RI, ACT_DECID, ACT_DECKPAM, ACT_DECKPNM, ACT_CUU,
        ACT_CUD, ACT_CUF, ACT_CUB, ACT_CUP, ACT_ANSI_MODE, ACT_GFX_ENTER,
        ACT_GFX_EXIT, ACT_ED, ACT_EL, ACT_VT52_IDENT, ACT_DECLL, ACT_DECSTBM,
        ACT_DECTST, ACT_SGR, ACT_DSR, ACT_DECREPTPARM, ACT_TBC, ACT_SM, ACT_RM,
        ACT_DEC_SM, ACT_DEC_RM, ACT_DHL_TOP, ACT_DHL_BOT, ACT_DECSWL, ACT_DECDWL,
        ACT_DECALN, ACT_G0_SET, ACT_G1_SET
    } action_t;

    typedef enum logic [1:0] {
        POP_NONE,
        POP_CLEAR,
        POP_ADD,
        POP_STORE
    } param_op_t;

    typedef struct packed {
        param_op_t          op;
        logic               emit;
        logic               with_params;
        action_t            action;
        logic [BYTE_W-1:0]  char_value;
    } ctrl_out_t;

endpackage

`default_nettype wire

@@ rtl/tesp_ctrl.sv @@
`default_nettype none

module tesp_ctrl import tesp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              ansi_mode,
    input  wire logic [FILL_W-1:0] param_fill,
    output ctrl_out_t              ctrl_out
);

    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic [FILL_W-1:0] cda_fill;

    // Hold the parse state between transactions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Fill count after a direct-cursor-address byte is stored
    assign cda_fill = (param_fill < FILL_W'(MAX_PARAMS)) ? param_fill + 1'b1 : param_fill;

    // Decode one byte against the current state
    always_comb begin
        state_next           = state_reg;
        ctrl_out.op          = POP_NONE;
        ctrl_out.emit        = 1'b0;
        ctrl_out.with_params = 1'b0;
        ctrl_out.action      = ACT_PRINT;
        ctrl_out.char_value  = '0;

        if (rx_byte < C_SPACE) begin
            // Controls act at once and keep the sequence, save ESC (restart) and CAN/SUB (abort)
            ctrl_out.emit = 1'b1;
            case (rx_byte)
                C_ESC: begin
                    ctrl_out.emit = 1'b0;
                    ctrl_out.op   = POP_CLEAR;
                    state_next    = ST_ESC;
                end
                C_ETX:                ctrl_out.action = ACT_ACK;
                C_ENQ:                ctrl_out.action = ACT_ANSWERBACK;
                C_BEL:                ctrl_out.action = ACT_BELL;
                C_HT:                 ctrl_out.action = ACT_HT;
                C_BS:                 ctrl_out.action = ACT_BS;
                C_LF, C_VT, C_FF:     ctrl_out.action = ACT_LF;
                C_CR:                 ctrl_out.action = ACT_CR;
                C_XON:                ctrl_out.action = ACT_XON;
                C_XOFF:               ctrl_out.action = ACT_XOFF;
                C_SI:                 ctrl_out.action = ACT_SI;
                C_SO:                 ctrl_out.action = ACT_SO;
                C_CAN, C_SUB: begin
                    // Abort the sequence and print the error glyph
                    state_next          = ST_IDLE;
                    ctrl_out.action     = ACT_PRINT;
                    ctrl_out.char_value = CHAR_ERR;
                end
                default:              ctrl_out.emit = 1'b0;
            endcase
        end else if (rx_byte != C_DEL) begin
            case (state_reg)
                ST_IDLE: begin
                    ctrl_out.emit       = 1'b1;
                    ctrl_out.char_value = rx_byte;
                end
                ST_ESC: begin
                    state_next           = ST_IDLE;
                    ctrl_out.emit        = 1'b1;
                    ctrl_out.with_params = 1'b1;
                    if (ansi_mode) begin
                        case (rx_byte)
                            "[": begin state_next = ST_CSI;  ctrl_out.emit = 1'b0; end
                            "#": begin state_next = ST_HASH; ctrl_out.emit = 1'b0; end
                            "(": begin state_next = ST_G0;   ctrl_out.emit = 1'b0; end
                            ")": begin state_next = ST_G1;   ctrl_out.emit = 1'b0; end
                            "O": begin state_next = ST_ESCO; ctrl_out.emit = 1'b0; end
                            "7":     ctrl_out.action = ACT_DECSC;
                            "8":     ctrl_out.action = ACT_DECRC;
                            "c":     ctrl_out.action = ACT_RIS;
                            "D":     ctrl_out.action = ACT_IND;
                            "E":     ctrl_out.action = ACT_NEL;
                            "H":     ctrl_out.action = ACT_HTS;
                            "M":     ctrl_out.action = ACT_RI;
                            "Z":     ctrl_out.action = ACT_DECID;
                            "=":     ctrl_out.action = ACT_DECKPAM;
                            ">":     ctrl_out.action = ACT_DECKPNM;
                            default: ctrl_out.emit   = 1'b0;
                        endcase
                    end else begin
                        case (rx_byte)
                            "Y": begin state_next = ST_CDA; ctrl_out.emit = 1'b0; end
                            "=":     ctrl_out.action = ACT_DECKPAM;
                            ">":     ctrl_out.action = ACT_DECKPNM;
                            "<":     ctrl_out.action = ACT_ANSI_MODE;
                            "A":     ctrl_out.action = ACT_CUU;
                            "B":     ctrl_out.action = ACT_CUD;
                            "C":     ctrl_out.action = ACT_CUF;
                            "D":     ctrl_out.action = ACT_CUB;
                            "F":     ctrl_out.action = ACT_GFX_ENTER;
                            "G":     ctrl_out.action = ACT_GFX_EXIT;
                            "H":     ctrl_out.action = ACT_CUP;
                            "I":     ctrl_out.action = ACT_RI;
                            "J":     ctrl_out.action = ACT_ED;
                            "K":     ctrl_out.action = ACT_EL;
                            "Z":     ctrl_out.action = ACT_VT52_IDENT;
                            default: ctrl_out.emit   = 1'b0;
                        endcase
                    end
                end
                ST_CSI: begin
                    state_next           = ST_IDLE;
                    ctrl_out.emit        = 1'b1;
                    ctrl_out.with_params = 1'b1;
                    case (rx_byte)
                        "?": begin state_next = ST_PRIV; ctrl_out.emit = 1'b0; end
                        "A":      ctrl_out.action = ACT_CUU;
                        "B":      ctrl_out.action = ACT_CUD;
                        "C":      ctrl_out.action = ACT_CUF;
                        "D":      ctrl_out.action = ACT_CUB;
                        "H", "f": ctrl_out.action = ACT_CUP;
                        "c":      ctrl_out.action = ACT_DECID;
                        "q":      ctrl_out.action = ACT_DECLL;
                        "r":      ctrl_out.action = ACT_DECSTBM;
                        "y":      ctrl_out.action = ACT_DECTST;
                        "J":      ctrl_out.action = ACT_ED;
                        "K":      ctrl_out.action = ACT_EL;
                        "m":      ctrl_out.action = ACT_SGR;
                        "n":      ctrl_out.action = ACT_DSR;
                        "x":      ctrl_out.action = ACT_DECREPTPARM;
                        "g":      ctrl_out.action = ACT_TBC;
                        "h":      ctrl_out.action = ACT_SM;
                        "l":      ctrl_out.action = ACT_RM;
                        default: begin
                            // Collect parameter bytes, stay in the sequence
                            state_next    = ST_CSI;
                            ctrl_out.emit = 1'b0;
                            ctrl_out.op   = POP_ADD;
                        end
                    endcase
                end
                ST_PRIV: begin
                    if (rx_byte == "h" || rx_byte == "l") begin
                        state_next           = ST_IDLE;
                        ctrl_out.emit        = 1'b1;
                        ctrl_out.with_params = 1'b1;
                        ctrl_out.action      = (rx_byte == "h") ? ACT_DEC_SM : ACT_DEC_RM;
                    end else begin
                        ctrl_out.op = POP_ADD;
                    end
                end
                ST_HASH: begin
                    state_next           = ST_IDLE;
                    ctrl_out.emit        = 1'b1;
                    ctrl_out.with_params = 1'b1;
                    case (rx_byte)
                        "3":     ctrl_out.action = ACT_DHL_TOP;
                        "4":     ctrl_out.action = ACT_DHL_BOT;
                        "5":     ctrl_out.action = ACT_DECSWL;
                        "6":     ctrl_out.action = ACT_DECDWL;
                        "8":     ctrl_out.action = ACT_DECALN;
                        default: ctrl_out.emit   = 1'b0;
                    endcase
                end
                ST_G0, ST_G1: begin
                    state_next           = ST_IDLE;
                    ctrl_out.emit        = 1'b1;
                    ctrl_out.with_params = 1'b1;
                    ctrl_out.action      = (state_reg == ST_G0) ? ACT_G0_SET : ACT_G1_SET;
                    case (rx_byte)
                        "A":     ctrl_out.char_value = CS_UK;
                        "B":     ctrl_out.char_value = CS_ASCII;
                        "0":     ctrl_out.char_value = CS_GRAPHICS;
                        "1":     ctrl_out.char_value = CS_ALTROM;
                        "2":     ctrl_out.char_value = CS_ALTROM_GFX;
                        default: ctrl_out.emit       = 1'b0;
                    endcase
                end
                ST_ESCO: begin
                    state_next           = ST_IDLE;
                    ctrl_out.emit        = 1'b1;
                    ctrl_out.with_params = 1'b1;
                    case (rx_byte)
                        "A":     ctrl_out.action = ACT_CUU;
                        "B":     ctrl_out.action = ACT_CUD;
                        "C":     ctrl_out.action = ACT_CUF;
                        "D":     ctrl_out.action = ACT_CUB;
                        default: ctrl_out.char_value = rx_byte;
                    endcase
                end
                ST_CDA: begin
                    // Store row or column, report the cursor move after two
                    ctrl_out.op = POP_STORE;
                    if (cda_fill >= FILL_W'(2)) begin
                        state_next           = ST_IDLE;
                        ctrl_out.emit        = 1'b1;
                        ctrl_out.with_params = 1'b1;
                        ctrl_out.action      = ACT_CUP;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/tesp_params.sv @@
`default_nettype none

module tesp_params import tesp_pkg::*; (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             accept,
    input  wire param_op_t                        op,
    input  wire logic [BYTE_W-1:0]                rx_byte,
    output logic [FILL_W-1:0]                     fill_reg,
    output logic [FILL_W-1:0]                     fill_view,
    output logic [MAX_PARAMS-1:0][PARAM_W-1:0]    param_view
);

    logic [MAX_PARAMS-1:0][PARAM_W-1:0] slots_reg;
    logic [MAX_PARAMS-1:0][PARAM_W-1:0] slots_next;
    logic [FILL_W-1:0]                  fill_next;
    logic [FILL_W-1:0]                  eff_fill;
    logic                               is_digit;
    logic                               has_room;

    // Multiply by ten, add a digit, saturate at full scale
    function automatic logic [PARAM_W-1:0] mac10(input logic [PARAM_W-1:0] base,
                                                 input logic [3:0] digit);
        logic [PARAM_W+3:0] sum;
        sum = {base, 3'b000} + {2'b00, base, 1'b0} + {{PARAM_W{1'b0}}, digit};
        return (sum > {4'h0, {PARAM_W{1'b1}}}) ? {PARAM_W{1'b1}} : sum[PARAM_W-1:0];
    endfunction

    assign is_digit = (rx_byte >= "0") && (rx_byte <= "9");
    assign has_room = fill_reg < FILL_W'(MAX_PARAMS);
    assign eff_fill = (fill_reg == '0) ? FILL_W'(1) : fill_reg;

    // Apply the parameter operation for this transaction
    always_comb begin
        fill_next  = fill_reg;
        slots_next = slots_reg;
        if (accept) begin
            case (op)
                POP_CLEAR: begin
                    fill_next  = '0;
                    slots_next = '0;
                end
                POP_ADD: begin
                    if (rx_byte == ";") begin
                        // A leading separator leaves the first parameter empty and opens the second
                        if (fill_reg == '0) begin
                            slots_next[0] = '0;
                            slots_next[1] = '0;
                            fill_next     = FILL_W'(2);
                        end else if (has_room) begin
                            for (int i = 0; i < MAX_PARAMS; i++) begin
                                if (fill_reg == FILL_W'(i)) slots_next[i] = '0;
                            end
                            fill_next = fill_reg + 1'b1;
                        end
                    end else if (is_digit) begin
                        for (int i = 0; i < MAX_PARAMS; i++) begin
                            if (eff_fill == FILL_W'(i + 1)) begin
                                slots_next[i] = mac10((fill_reg == '0) ? '0 : slots_reg[i],
                                                      rx_byte[3:0]);
                            end
                        end
                        fill_next = eff_fill;
                    end
                end
                POP_STORE: begin
                    if (has_room) begin
                        for (int i = 0; i < MAX_PARAMS; i++) begin
                            if (fill_reg == FILL_W'(i)) begin
                                slots_next[i] = PARAM_W'(rx_byte - C_SPACE + 8'd1);
                            end
                        end
                        fill_next = fill_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold the collected parameters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            slots_reg <= '0;
        end else begin
            fill_reg  <= fill_next;
            slots_reg <= slots_next;
        end
    end

    // Present updated parameters, zero beyond the fill count
    always_comb begin
        fill_view = fill_next;
        for (int i = 0; i < MAX_PARAMS; i++) begin
            param_view[i] = (FILL_W'(i) < fill_next) ? slots_next[i] : '0;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAX_PARAMS))
        else $error("parameter fill count exceeds slot count");

    a_clear_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == POP_CLEAR) |=> (fill_reg == '0 && slots_reg == '0))
        else $error("escape did not clear parameters");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == POP_STORE) |=> (fill_reg >= $past(fill_reg)))
        else $error("cursor address store lowered the fill count");

endmodule

`default_nettype wire

@@ rtl/terminal_escape_sequence_parser_unit.sv @@
`default_nettype none

// A result is registered on m_tdata in the cycle after its byte is accepted.
// Throughput: one byte per cycle while m_tvalid is low or m_tready is high; the
// decode stage feeds a single output register, reloaded in the cycle it empties.
// Bytes that cause no action (ESC, DEL, sequence bytes) produce no transaction.
// Reset: parser idle, parameters cleared, ansi_mode set to 1, output empty.
module terminal_escape_sequence_parser_unit import tesp_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,    // ansi_mode
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [BYTE_W-1:0]  s_tdata,        // rx_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // action[5:0], char_value[13:6], param_count[16:14], param_first[32:17],
    // param_second[48:33], param_third[64:49], param_fourth[80:65], zero above
    output logic [TDATA_W-1:0]      m_tdata
);

    logic                                ansi_mode_reg;
    logic                                m_tvalid_reg;
    logic                                m_tvalid_next;
    logic [TDATA_W-1:0]                  m_tdata_reg;
    logic                                accept;
    ctrl_out_t                           ctrl_out;
    logic [FILL_W-1:0]                   fill_reg;
    logic [FILL_W-1:0]                   fill_view;
    logic [MAX_PARAMS-1:0][PARAM_W-1:0]  param_view;
    logic [OUT_SLOTS-1:0][PARAM_W-1:0]   param_out;
    logic [FILL_W-1:0]                   count_out;

    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Hold the decode mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ansi_mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            ansi_mode_reg <= cfg_wr_data;
        end
    end

    tesp_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .rx_byte    (s_tdata),
        .ansi_mode  (ansi_mode_reg),
        .param_fill (fill_reg),
        .ctrl_out   (ctrl_out)
    );

    tesp_params u_params (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (ctrl_out.op),
        .rx_byte    (s_tdata),
        .fill_reg   (fill_reg),
        .fill_view  (fill_view),
        .param_view (param_view)
    );

    // Map parameter slots onto the four result fields
    for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_param_out
        if (g < MAX_PARAMS) begin : g_used
            assign param_out[g] = ctrl_out.with_params ? param_view[g] : '0;
        end else begin : g_unused
            assign param_out[g] = '0;
        end
    end

    assign count_out = ctrl_out.with_params ? fill_view : '0;

    // Advance the output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept && ctrl_out.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && ctrl_out.emit) begin
            m_tdata_reg <= {7'b0, param_out[3], param_out[2], param_out[1], param_out[0],
                            count_out, ctrl_out.char_value, ctrl_out.action};
        end
    end

    a_cancel_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tdata == C_CAN || s_tdata == C_SUB)) |=>
            (m_tvalid && m_tdata[5:0] == ACT_PRINT && m_tdata[13:6] == CHAR_ERR
             && m_tdata[16:14] == '0))
        else $error("cancel byte did not produce the error glyph");

    a_del_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tdata == C_DEL && (!m_tvalid_reg || m_tready)) |=> !m_tvalid_reg)
        else $error("DEL produced a transaction");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:14] <= FILL_W'(MAX_PARAMS)))
        else $error("reported parameter count out of range");

    a_esc_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tdata == C_ESC && (!m_tvalid_reg || m_tready)) |=> !m_tvalid_reg)
        else $error("ESC produced a transaction");

endmodule

`default_nettype wire

@@ sim/terminal_escape_sequence_parser_unit_tb.sv @@
module terminal_escape_sequence_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tesp_pkg::*;

    // Result field positions on m_tdata
    localparam int ACT_LSB  = 0;
    localparam int CHAR_LSB = ACT_LSB + ACTION_W;
    localparam int CNT_LSB  = CHAR_LSB + BYTE_W;
    localparam int PRM_LSB  = CNT_LSB + FILL_W;
    localparam int PAD_LSB  = PRM_LSB + OUT_SLOTS * PARAM_W;

    typedef struct packed {
        action_t                           act;
        logic [BYTE_W-1:0]                 ch;
        logic [FILL_W-1:0]                 cnt;
        logic [OUT_SLOTS-1:0][PARAM_W-1:0] prm;
    } parser_action_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;

    // Decoder prediction state
    logic               ansi_sel;
    parse_state_t       seq_state;
    logic [PARAM_W-1:0] num_val [MAX_PARAMS];
    int unsigned        num_cnt;

    parser_action_t     pending_actions[$];
    int unsigned        mismatch_count;
    int unsigned        bytes_sent;
    bit                 tx_no_idle;
    bit                 rx_no_idle;
    int unsigned        rx_hold_cycles;

    terminal_escape_sequence_parser_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the handshakes hang
    initial begin
        #10_000_000;
        $display("terminal_escape_sequence_parser_unit_tb NOT OK");
        $finish;
    end

    //--------------------------------------------------------------------
    // Prediction
    //--------------------------------------------------------------------

    function automatic void queue_action(action_t a, logic [BYTE_W-1:0] ch, bit with_nums);
        parser_action_t r;
        r.act = a;
        r.ch  = ch;
        r.cnt = with_nums ? FILL_W'(num_cnt) : '0;
        for (int i = 0; i < OUT_SLOTS; i++)
            r.prm[i] = (with_nums && i < num_cnt) ? num_val[i] : '0;
        pending_actions.push_back(r);
    endfunction

    // Build decimal parameters; ';' opens a new one until all slots are used
    function automatic void collect_num_char(logic [BYTE_W-1:0] b);
        int unsigned acc;
        if (b == ";") begin
            if (num_cnt == 0) begin
                num_val[0] = '0;
                num_val[1] = '0;
                num_cnt    = 2;
            end else if (num_cnt < MAX_PARAMS) begin
                num_val[num_cnt] = '0;
                num_cnt++;
            end
        end else if (b >= "0" && b <= "9") begin
            if (num_cnt == 0) begin
                num_cnt    = 1;
                num_val[0] = '0;
            end
            acc = num_val[num_cnt-1] * 10 + (b - "0");
            num_val[num_cnt-1] = (acc > 65535) ? '1 : PARAM_W'(acc);
        end
    endfunction

    function automatic void decode_charset(action_t a, logic [BYTE_W-1:0] b);
        seq_state = ST_IDLE;
        case (b)
            "A":     queue_action(a, CS_UK, 1'b1);
            "B":     queue_action(a, CS_ASCII, 1'b1);
            "0":     queue_action(a, CS_GRAPHICS, 1'b1);
            "1":     queue_action(a, CS_ALTROM, 1'b1);
            "2":     queue_action(a, CS_ALTROM_GFX, 1'b1);
            default: ;
        endcase
    endfunction

    // Print never ends an escape sequence, so it stands for "no action" here
    function automatic void decode_esc_final(logic [BYTE_W-1:0] b);
        action_t a;
        a = ACT_PRINT;
        seq_state = ST_IDLE;
        if (ansi_sel) begin
            case (b)
                "[":     seq_state = ST_CSI;
                "#":     seq_state = ST_HASH;
                "(":     seq_state = ST_G0;
                ")":     seq_state = ST_G1;
                "O":     seq_state = ST_ESCO;
                "7":     a = ACT_DECSC;
                "8":     a = ACT_DECRC;
                "c":     a = ACT_RIS;
                "D":     a = ACT_IND;
                "E":     a = ACT_NEL;
                "H":     a = ACT_HTS;
                "M":     a = ACT_RI;
                "Z":     a = ACT_DECID;
                "=":     a = ACT_DECKPAM;
                ">":     a = ACT_DECKPNM;
                default: ;
            endcase
        end else begin
            case (b)
                "Y":     seq_state = ST_CDA;
                "=":     a = ACT_DECKPAM;
                ">":     a = ACT_DECKPNM;
                "<":     a = ACT_ANSI_MODE;
                "A":     a = ACT_CUU;
                "B":     a = ACT_CUD;
                "C":     a = ACT_CUF;
                "D":     a = ACT_CUB;
                "F":     a = ACT_GFX_ENTER;
                "G":     a = ACT_GFX_EXIT;
                "H":     a = ACT_CUP;
                "I":     a = ACT_RI;
                "J":     a = ACT_ED;
                "K":     a = ACT_EL;
                "Z":     a = ACT_VT52_IDENT;
                default: ;
            endcase
        end
        if (a != ACT_PRINT)
            queue_action(a, '0, 1'b1);
    endfunction

    function automatic void decode_csi_final(logic [BYTE_W-1:0] b);
        action_t a;
        a = ACT_PRINT;
        case (b)
            "?":      seq_state = ST_PRIV;
            "A":      a = ACT_CUU;
            "B":      a = ACT_CUD;
            "C":      a = ACT_CUF;
            "D":      a = ACT_CUB;
            "H", "f": a = ACT_CUP;
            "c":      a = ACT_DECID;
            "q":      a = ACT_DECLL;
            "r":      a = ACT_DECSTBM;
            "y":      a = ACT_DECTST;
            "J":      a = ACT_ED;
            "K":      a = ACT_EL;
            "m":      a = ACT_SGR;
            "n":      a = ACT_DSR;
            "x":      a = ACT_DECREPTPARM;
            "g":      a = ACT_TBC;
            "h":      a = ACT_SM;
            "l":      a = ACT_RM;
            default:  collect_num_char(b);
        endcase
        if (a != ACT_PRINT) begin
            seq_state = ST_IDLE;
            queue_action(a, '0, 1'b1);
        end
    endfunction

    function automatic void predict_parser_byte(logic [BYTE_W-1:0] b);
        action_t a;
        if (b < C_SPACE) begin
            // Controls act at once and keep any open sequence, save ESC (restart) and CAN/SUB (abort)
            case (b)
                C_ESC: begin
                    seq_state = ST_ESC;
                    num_cnt   = 0;
                    for (int i = 0; i < MAX_PARAMS; i++)
                        num_val[i] = '0;
                end
                C_ETX:             queue_action(ACT_ACK, '0, 1'b0);
                C_ENQ:             queue_action(ACT_ANSWERBACK, '0, 1'b0);
                C_BEL:             queue_action(ACT_BELL, '0, 1'b0);
                C_HT:              queue_action(ACT_HT, '0, 1'b0);
                C_BS:              queue_action(ACT_BS, '0, 1'b0);
                C_LF, C_VT, C_FF:  queue_action(ACT_LF, '0, 1'b0);
                C_CR:              queue_action(ACT_CR, '0, 1'b0);
                C_XON:             queue_action(ACT_XON, '0, 1'b0);
                C_XOFF:            queue_action(ACT_XOFF, '0, 1'b0);
                C_SI:              queue_action(ACT_SI, '0, 1'b0);
                C_SO:              queue_action(ACT_SO, '0, 1'b0);
                C_CAN, C_SUB: begin
                    seq_state = ST_IDLE;
                    queue_action(ACT_PRINT, CHAR_ERR, 1'b0);
                end
                default: ;
            endcase
        end else if (b != C_DEL) begin
            case (seq_state)
                ST_IDLE: queue_action(ACT_PRINT, b, 1'b0);
                ST_ESC:  decode_esc_final(b);
                ST_CSI:  decode_csi_final(b);
                ST_PRIV: begin
                    if (b == "h" || b == "l") begin
                        seq_state = ST_IDLE;
                        if (b == "h")
                            queue_action(ACT_DEC_SM, '0, 1'b1);
                        else
                            queue_action(ACT_DEC_RM, '0, 1'b1);
                    end else begin
                        collect_num_char(b);
                    end
                end
                ST_HASH: begin
                    seq_state = ST_IDLE;
                    a = ACT_PRINT;
                    case (b)
                        "3":     a = ACT_DHL_TOP;
                        "4":     a = ACT_DHL_BOT;
                        "5":     a = ACT_DECSWL;
                        "6":     a = ACT_DECDWL;
                        "8":     a = ACT_DECALN;
                        default: ;
                    endcase
                    if (a != ACT_PRINT)
                        queue_action(a, '0, 1'b1);
                end
                ST_G0:   decode_charset(ACT_G0_SET, b);
                ST_G1:   decode_charset(ACT_G1_SET, b);
                ST_ESCO: begin
                    seq_state = ST_IDLE;
                    case (b)
                        "A":     queue_action(ACT_CUU, '0, 1'b1);
                        "B":     queue_action(ACT_CUD, '0, 1'b1);
                        "C":     queue_action(ACT_CUF, '0, 1'b1);
                        "D":     queue_action(ACT_CUB, '0, 1'b1);
                        default: queue_action(ACT_PRINT, b, 1'b1);
                    endcase
                end
                ST_CDA: begin
                    // VT52 direct addressing: row and column are offset by space
                    if (num_cnt < MAX_PARAMS) begin
                        num_val[num_cnt] = PARAM_W'(b) - PARAM_W'(C_SPACE) + 1'b1;
                        num_cnt++;
                    end
                    if (num_cnt >= 2) begin
                        seq_state = ST_IDLE;
                        queue_action(ACT_CUP, '0, 1'b1);
                    end
                end
                default: seq_state = ST_IDLE;
            endcase
        end
    endfunction

    //--------------------------------------------------------------------
    // Checking
    //--------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [PARAM_W-1:0] got,
                               input logic [PARAM_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Compare every result transaction with the oldest pending action
    always @(posedge aclk) begin : action_checker
        parser_action_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_actions.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, action %0d",
                                          m_tdata[ACT_LSB +: ACTION_W]));
            end else begin
                want = pending_actions.pop_front();
                check_field("action", PARAM_W'(m_tdata[ACT_LSB +: ACTION_W]),
                            PARAM_W'(want.act));
                check_field("char_value", PARAM_W'(m_tdata[CHAR_LSB +: BYTE_W]),
                            PARAM_W'(want.ch));
                check_field("param_count", PARAM_W'(m_tdata[CNT_LSB +: FILL_W]),
                            PARAM_W'(want.cnt));
                for (int i = 0; i < OUT_SLOTS; i++)
                    check_field($sformatf("param[%0d]", i),
                                m_tdata[PRM_LSB + i*PARAM_W +: PARAM_W], want.prm[i]);
                check_field("padding", PARAM_W'(m_tdata[TDATA_W-1:PAD_LSB]), '0);
            end
        end
    end

    //--------------------------------------------------------------------
    // Result sink: random stalls, plus a long hold when requested
    //--------------------------------------------------------------------

    initial begin : result_sink
        int unsigned stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            stall = rx_no_idle ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    //--------------------------------------------------------------------
    // Byte source
    //--------------------------------------------------------------------

    // Offer one byte after a random gap; valid stays high into the next byte
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_parser_byte(b);
        if (b != C_DEL)
            bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Drop valid, drain pending actions and let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_actions.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_ansi_mode(input bit m);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ansi_sel = m;
    endtask

    function automatic logic [BYTE_W-1:0] pick_char(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Mostly a legal choice, sometimes any byte
    function automatic logic [BYTE_W-1:0] maybe_from(string s);
        if ($urandom_range(0, 4) == 0)
            return BYTE_W'($urandom_range(0, 255));
        return pick_char(s);
    endfunction

    // Control byte or arbitrary character dropped into a sequence
    function automatic logic [BYTE_W-1:0] stray_byte();
        if ($urandom_range(0, 1) == 0)
            return BYTE_W'($urandom_range(0, 31));
        return BYTE_W'($urandom_range(32, 255));
    endfunction

    task automatic send_csi_sequence(input bit dec_form);
        int unsigned nums;
        int unsigned digits;
        send_byte("[");
        if (dec_form)
            send_byte("?");
        nums = $urandom_range(0, 5);
        for (int i = 0; i < nums; i++) begin
            if (i > 0 || $urandom_range(0, 7) == 0)
                send_byte(";");
            digits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
            repeat (digits)
                send_byte(BYTE_W'("0") + BYTE_W'($urandom_range(0, 9)));
            if ($urandom_range(0, 11) == 0)
                send_byte(stray_byte());
        end
        if ($urandom_range(0, 9) == 0)
            send_byte(BYTE_W'($urandom_range(0, 255)));
        else if (dec_form)
            send_byte(pick_char("hl"));
        else
            send_byte(pick_char("ABCDHfcqryJKmnxghl"));
    endtask

    task automatic send_ansi_sequence();
        send_byte(C_ESC);
        case ($urandom_range(0, 9))
            0, 1:    send_byte(maybe_from("78cDEHMZ=>"));
            2, 3, 4: send_csi_sequence(1'b0);
            5:       send_csi_sequence(1'b1);
            6: begin
                send_byte("#");
                send_byte(maybe_from("34568"));
            end
            7: begin
                send_byte($urandom_range(0, 1) ? "(" : ")");
                send_byte(maybe_from("AB012"));
            end
            8: begin
                send_byte("O");
                send_byte(maybe_from("ABCD"));
            end
            default: send_byte(BYTE_W'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_vt52_sequence();
        logic [BYTE_W-1:0] fin;
        send_byte(C_ESC);
        fin = maybe_from("YABCDFGHIJKZ<=>");
        send_byte(fin);
        if (fin == "Y") begin
            repeat (2) begin
                if ($urandom_range(0, 9) == 0)
                    send_byte(stray_byte());
                send_byte(BYTE_W'($urandom_range(32, 255)));
            end
        end
    endtask

    //--------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------

    task automatic test_extremes();
        set_ansi_mode(1'b1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(C_DEL);
        send_byte(C_SPACE);
        send_byte(C_ETX);
    endtask

    // Leading separator, saturation, surplus separators, private form
    task automatic test_csi_parameters();
        send_byte(C_ESC);
        send_text("[;70000H");
        send_byte(C_ESC);
        send_text("[9;;;;7m");
        send_byte(C_ESC);
        send_text("[?25h");
    endtask

    task automatic test_sequence_interrupts();
        send_byte(C_ESC);
        send_text("[5");
        send_byte(C_BEL);
        send_byte("A");
        send_byte(C_ESC);
        send_text("[3");
        send_byte(C_CAN);
        send_byte(C_ESC);
        send_text("Ox");
        send_byte(C_ESC);
        send_byte("1");
        send_byte(C_ESC);
        send_text("#8");
        send_byte(C_ESC);
        send_text("(0");
    endtask

    task automatic test_vt52_addressing();
        set_ansi_mode(1'b0);
        send_byte(C_ESC);
        send_byte("Y");
        send_byte(C_SPACE);
        send_byte(8'hFF);
        send_byte(C_ESC);
        send_byte("H");
    endtask

    // Hold the sink while bytes keep coming so the output fills and input stalls
    task automatic test_output_backpressure();
        send_byte(C_CAN);
        tx_no_idle     = 1'b1;
        rx_hold_cycles = 150;
        repeat (40)
            send_byte(BYTE_W'($urandom_range(32, 126)));
        tx_no_idle = 1'b0;
    endtask

    task automatic test_random_stream(input bit ansi, input int unsigned count);
        int unsigned stop_at;
        set_ansi_mode(ansi);
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 24) == 0)
                tx_no_idle = ~tx_no_idle;
            if ($urandom_range(0, 24) == 0)
                rx_no_idle = ~rx_no_idle;
            case ($urandom_range(0, 9))
                0: send_byte(BYTE_W'($urandom_range(0, 255)));
                1: repeat ($urandom_range(1, 8))
                       send_byte(BYTE_W'($urandom_range(32, 255)));
                default: begin
                    if (ansi)
                        send_ansi_sequence();
                    else
                        send_vt52_sequence();
                end
            endcase
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    initial begin : stimulus
        mismatch_count = 0;
        bytes_sent     = 0;
        tx_no_idle     = 1'b0;
        rx_no_idle     = 1'b0;
        rx_hold_cycles = 0;
        ansi_sel       = 1'b1;
        seq_state      = ST_IDLE;
        num_cnt        = 0;
        for (int i = 0; i < MAX_PARAMS; i++)
            num_val[i] = '0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_extremes();
        test_csi_parameters();
        test_sequence_interrupts();
        test_vt52_addressing();
        test_output_backpressure();
        test_random_stream(1'b1, 350);
        test_random_stream(1'b0, 300);
        test_random_stream(1'b1, 200);
        test_random_stream(1'b0, 150);
        wait_idle();

        if (mismatch_count == 0 && pending_actions.size() == 0) begin
            $display("terminal_escape_sequence_parser_unit_tb OK");
        end else begin
            $display("terminal_escape_sequence_parser_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/tesp_pkg.sv
rtl/tesp_ctrl.sv
rtl/tesp_params.sv
rtl/terminal_escape_sequence_parser_unit.sv
sim/terminal_escape_sequence_parser_unit_tb.sv
